>>> hw/rtl/encoder_move_controller_defines.svh
// assertion macros for the encoder move controller
// used by encoder_move_controller.sv, expects clk and rst_n in scope
`ifndef ENCODER_MOVE_CONTROLLER_DEFINES_SVH
`define ENCODER_MOVE_CONTROLLER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define EMC_ASSERT_NOW(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define EMC_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
    else $error(msg);

`endif

>>> hw/rtl/emc_pkg.sv
// types and constants for the encoder move controller
// no dependencies
package emc_pkg;

  // input actions
  localparam logic [3:0] ACT_LEFT_TICK  = 4'd0;
  localparam logic [3:0] ACT_RIGHT_TICK = 4'd1;
  localparam logic [3:0] ACT_CHECK      = 4'd2;
  localparam logic [3:0] ACT_CLEAR      = 4'd3;
  localparam logic [3:0] ACT_STOP       = 4'd4;
  localparam logic [3:0] ACT_FWD        = 4'd5;
  localparam logic [3:0] ACT_REV        = 4'd6;
  localparam logic [3:0] ACT_LEFT       = 4'd7;
  localparam logic [3:0] ACT_RIGHT      = 4'd8;

  // heading modes
  localparam logic [2:0] MODE_STOP  = 3'd0;
  localparam logic [2:0] MODE_FWD   = 3'd1;
  localparam logic [2:0] MODE_REV   = 3'd2;
  localparam logic [2:0] MODE_LEFT  = 3'd3;
  localparam logic [2:0] MODE_RIGHT = 3'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_CM_PER_TICK   = 2'd0;
  localparam logic [1:0] CFG_TICKS_PER_DEG = 2'd1;
  localparam logic [1:0] CFG_RIGHT_TRIM    = 2'd2;
  localparam logic [1:0] CFG_RIGHT_TURN    = 2'd3;

  // configuration reset values
  localparam logic [15:0] CM_PER_TICK_RST   = 16'd6691;
  localparam logic [11:0] TICKS_PER_DEG_RST = 12'd374;
  localparam logic [3:0]  RIGHT_TRIM_RST    = 4'd5;
  localparam logic [3:0]  RIGHT_TURN_RST    = 4'd7;

  // open-ended targets
  localparam logic [23:0] DIST_FOREVER  = 24'd9999999;
  localparam logic [26:0] TICKS_FOREVER = 27'd99999999;

  // pct*255/100 as one multiply by 255*ceil(2^19/100) and a shift by 19,
  // exact for pct up to 100
  localparam logic [6:0]  SPEED_MAX       = 7'd100;
  localparam logic [20:0] SPEED_SCALE_MUL = 21'd1336965;

  typedef struct packed {
    logic [3:0]  action;
    logic [15:0] amount;
    logic [7:0]  speed_pct;
    logic        obstacle_near;
  } emc_in_t;

  typedef struct packed {
    logic [7:0]  duty_left_fwd;
    logic [7:0]  duty_left_rev;
    logic [7:0]  duty_right_fwd;
    logic [7:0]  duty_right_rev;
    logic [2:0]  heading_mode;
    logic [31:0] dist_forward_cm;
    logic [31:0] dist_reverse_cm;
    logic        halted_now;
  } emc_out_t;

endpackage

>>> hw/rtl/encoder_move_controller.sv
// encoder move controller top level: command decode, tick counters, goal checks
// depends on emc_pkg and encoder_move_controller_defines.svh
//
//  port group | direction | handshake          | payload
//  in_*       | input     | in_valid/in_ready   | emc_in_t  (action, amount, speed, obstacle)
//  out_*      | output    | out_valid/out_ready | emc_out_t (duties, mode, distances, halt)
//  cfg_*      | input     | cfg_we only         | cfg_index, cfg_wdata
//
// one item per cycle sustained while out_ready is high; input register, then result register
// the path that sets the clock is tick counter increment into the shared 32x16 distance multiply
// synchronous active-low reset, no clearing pass; all state is in flip-flops
// a stalled result blocks the item behind it; in_ready needs an empty or advancing input register
`include "encoder_move_controller_defines.svh"

module encoder_move_controller
  import emc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // command / event channel
  input  logic        in_valid,
  output logic        in_ready,
  input  emc_in_t     in_data,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output emc_out_t    out_data,
  // configuration writes
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  // configuration registers
  logic [15:0] cm_per_tick_r;
  logic [11:0] ticks_per_deg_r;
  logic [3:0]  right_trim_r;
  logic [3:0]  right_turn_trim_r;

  // input and result stages
  logic        in_valid_r;
  emc_in_t     in_data_r;
  logic        out_valid_r;
  emc_out_t    out_data_r;
  logic        advance;

  // controller state
  logic [2:0]  mode_r,        mode_nxt;
  logic [31:0] lf_cnt_r,      lf_cnt_nxt;
  logic [31:0] lr_cnt_r,      lr_cnt_nxt;
  logic [31:0] lt_cnt_r,      lt_cnt_nxt;
  logic [31:0] rt_cnt_r,      rt_cnt_nxt;
  logic [31:0] fwd_dist_r,    fwd_dist_nxt;
  logic [31:0] rev_dist_r,    rev_dist_nxt;
  logic [23:0] dist_req_r,    dist_req_nxt;
  logic [31:0] dist_goal_r,   dist_goal_nxt;
  logic [26:0] tick_req_r,    tick_req_nxt;
  logic [31:0] tick_goal_r,   tick_goal_nxt;
  logic [7:0]  duty_r   [4];
  logic [7:0]  duty_nxt [4];
  logic        halted;

  // datapath helpers
  logic [6:0]  pct_clamp;
  logic [27:0] speed_prod;
  logic [7:0]  speed_duty;
  logic [7:0]  duty_trim;
  logic [7:0]  duty_turn_trim;
  logic [31:0] tick_sel;
  logic [47:0] cm_prod;
  logic [27:0] turn_prod;
  logic [26:0] turn_req;
  logic [23:0] arm_dist_req;
  logic        dist_hit;
  logic        tick_hit;

  // wheel idle flags for the checks at the end
  logic        out_duty_zero;
  logic        duty_zero;

  // item in the input register moves on when the result register is free or draining
  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // speed scaling and right-wheel trims, saturating at zero
  assign pct_clamp  = (in_data_r.speed_pct > {1'b0, SPEED_MAX}) ? SPEED_MAX
                                                                : in_data_r.speed_pct[6:0];
  assign speed_prod = 28'(pct_clamp) * 28'(SPEED_SCALE_MUL);
  assign speed_duty = speed_prod[26:19];
  assign duty_trim      = (speed_duty > {4'd0, right_trim_r})
                          ? (speed_duty - {4'd0, right_trim_r}) : 8'd0;
  assign duty_turn_trim = (speed_duty > {4'd0, right_turn_trim_r})
                          ? (speed_duty - {4'd0, right_turn_trim_r}) : 8'd0;

  // one multiplier serves both straight modes, only one of them counts on a tick
  assign tick_sel = (mode_r == MODE_FWD) ? (lf_cnt_r + 32'd1) : (lr_cnt_r + 32'd1);
  assign cm_prod  = 48'(tick_sel) * 48'(cm_per_tick_r);

  // turn target in ticks, open-ended when no angle is given
  assign turn_prod    = 28'(in_data_r.amount) * 28'(ticks_per_deg_r);
  assign turn_req     = (in_data_r.amount == 16'd0) ? TICKS_FOREVER : 27'(turn_prod[27:8]);
  assign arm_dist_req = (in_data_r.amount == 16'd0) ? DIST_FOREVER : 24'(in_data_r.amount);

  // goal checks, only meaningful on a check item
  always_comb begin
    dist_hit = 1'b0;
    tick_hit = 1'b0;
    if (dist_req_r != 24'd0) begin
      case (mode_r)
        MODE_FWD:  dist_hit = (fwd_dist_r >= dist_goal_r) || in_data_r.obstacle_near;
        MODE_REV:  dist_hit = (rev_dist_r >= dist_goal_r);
        MODE_STOP: dist_hit = 1'b1;
        default:   dist_hit = 1'b0;
      endcase
    end
    if (tick_req_r != 27'd0) begin
      case (mode_r)
        MODE_LEFT:  tick_hit = (lt_cnt_r >= tick_goal_r);
        MODE_RIGHT: tick_hit = (rt_cnt_r >= tick_goal_r);
        MODE_STOP:  tick_hit = 1'b1;
        default:    tick_hit = 1'b0;
      endcase
    end
  end

  // next state for the item in the input register
  always_comb begin
    mode_nxt      = mode_r;
    lf_cnt_nxt    = lf_cnt_r;
    lr_cnt_nxt    = lr_cnt_r;
    lt_cnt_nxt    = lt_cnt_r;
    rt_cnt_nxt    = rt_cnt_r;
    fwd_dist_nxt  = fwd_dist_r;
    rev_dist_nxt  = rev_dist_r;
    dist_req_nxt  = dist_req_r;
    dist_goal_nxt = dist_goal_r;
    tick_req_nxt  = tick_req_r;
    tick_goal_nxt = tick_goal_r;
    duty_nxt      = duty_r;
    halted        = 1'b0;
    case (in_data_r.action)
      ACT_LEFT_TICK: begin
        if (mode_r == MODE_FWD) begin
          lf_cnt_nxt   = tick_sel;
          fwd_dist_nxt = cm_prod[47:16];
        end else if (mode_r == MODE_REV) begin
          lr_cnt_nxt   = tick_sel;
          rev_dist_nxt = cm_prod[47:16];
        end else if (mode_r == MODE_LEFT) begin
          lt_cnt_nxt = lt_cnt_r + 32'd1;
        end
      end
      ACT_RIGHT_TICK: begin
        if (mode_r == MODE_RIGHT) begin
          rt_cnt_nxt = rt_cnt_r + 32'd1;
        end
      end
      ACT_CHECK: begin
        if (dist_hit) begin
          dist_req_nxt  = 24'd0;
          dist_goal_nxt = 32'd0;
        end
        if (tick_hit) begin
          tick_req_nxt  = 27'd0;
          tick_goal_nxt = 32'd0;
        end
        // halt keeps the mode, only the wheels stop
        halted = dist_hit || tick_hit;
        if (halted) begin
          duty_nxt = '{8'd0, 8'd0, 8'd0, 8'd0};
        end
      end
      ACT_CLEAR: begin
        lf_cnt_nxt   = 32'd0;
        lr_cnt_nxt   = 32'd0;
        lt_cnt_nxt   = 32'd0;
        rt_cnt_nxt   = 32'd0;
        fwd_dist_nxt = 32'd0;
        rev_dist_nxt = 32'd0;
      end
      ACT_STOP: begin
        mode_nxt = MODE_STOP;
        duty_nxt = '{8'd0, 8'd0, 8'd0, 8'd0};
      end
      ACT_FWD: begin
        mode_nxt      = MODE_FWD;
        dist_req_nxt  = arm_dist_req;
        dist_goal_nxt = fwd_dist_r + 32'(arm_dist_req);
        duty_nxt      = '{speed_duty, 8'd0, duty_trim, 8'd0};
      end
      ACT_REV: begin
        mode_nxt      = MODE_REV;
        dist_req_nxt  = arm_dist_req;
        dist_goal_nxt = rev_dist_r + 32'(arm_dist_req);
        duty_nxt      = '{8'd0, speed_duty, 8'd0, duty_trim};
      end
      ACT_LEFT: begin
        mode_nxt      = MODE_LEFT;
        tick_req_nxt  = turn_req;
        tick_goal_nxt = lt_cnt_r + 32'(turn_req);
        duty_nxt      = '{8'd0, speed_duty, duty_trim, 8'd0};
      end
      ACT_RIGHT: begin
        mode_nxt      = MODE_RIGHT;
        tick_req_nxt  = turn_req;
        tick_goal_nxt = rt_cnt_r + 32'(turn_req);
        duty_nxt      = '{speed_duty, 8'd0, 8'd0, duty_turn_trim};
      end
      default: begin
        // unused action codes leave everything as it is
      end
    endcase
  end

  // handshake stages and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r        <= 1'b0;
      out_valid_r       <= 1'b0;
      cm_per_tick_r     <= CM_PER_TICK_RST;
      ticks_per_deg_r   <= TICKS_PER_DEG_RST;
      right_trim_r      <= RIGHT_TRIM_RST;
      right_turn_trim_r <= RIGHT_TURN_RST;
    end else begin
      if (in_valid && in_ready) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_CM_PER_TICK:   cm_per_tick_r     <= cfg_wdata;
          CFG_TICKS_PER_DEG: ticks_per_deg_r   <= cfg_wdata[11:0];
          CFG_RIGHT_TRIM:    right_trim_r      <= cfg_wdata[3:0];
          CFG_RIGHT_TURN:    right_turn_trim_r <= cfg_wdata[3:0];
          default:           cm_per_tick_r     <= cm_per_tick_r;
        endcase
      end
    end
  end

  // payload registers, loaded on transfer
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data_r <= in_data;
    end
    if (advance) begin
      out_data_r.duty_left_fwd   <= duty_nxt[0];
      out_data_r.duty_left_rev   <= duty_nxt[1];
      out_data_r.duty_right_fwd  <= duty_nxt[2];
      out_data_r.duty_right_rev  <= duty_nxt[3];
      out_data_r.heading_mode    <= mode_nxt;
      out_data_r.dist_forward_cm <= fwd_dist_nxt;
      out_data_r.dist_reverse_cm <= rev_dist_nxt;
      out_data_r.halted_now      <= halted;
    end
  end

  // controller state, updated once per item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_STOP;
      lf_cnt_r    <= 32'd0;
      lr_cnt_r    <= 32'd0;
      lt_cnt_r    <= 32'd0;
      rt_cnt_r    <= 32'd0;
      fwd_dist_r  <= 32'd0;
      rev_dist_r  <= 32'd0;
      dist_req_r  <= 24'd0;
      dist_goal_r <= 32'd0;
      tick_req_r  <= 27'd0;
      tick_goal_r <= 32'd0;
      duty_r      <= '{8'd0, 8'd0, 8'd0, 8'd0};
    end else if (advance) begin
      mode_r      <= mode_nxt;
      lf_cnt_r    <= lf_cnt_nxt;
      lr_cnt_r    <= lr_cnt_nxt;
      lt_cnt_r    <= lt_cnt_nxt;
      rt_cnt_r    <= rt_cnt_nxt;
      fwd_dist_r  <= fwd_dist_nxt;
      rev_dist_r  <= rev_dist_nxt;
      dist_req_r  <= dist_req_nxt;
      dist_goal_r <= dist_goal_nxt;
      tick_req_r  <= tick_req_nxt;
      tick_goal_r <= tick_goal_nxt;
      duty_r      <= duty_nxt;
    end
  end

  assign out_duty_zero = ({out_data_r.duty_left_fwd, out_data_r.duty_left_rev,
                           out_data_r.duty_right_fwd, out_data_r.duty_right_rev} == 32'd0);
  assign duty_zero     = ({duty_r[0], duty_r[1], duty_r[2], duty_r[3]} == 32'd0);

  // a halt always leaves every wheel stopped
  `EMC_ASSERT_NOW(a_halt_stops, out_valid_r && out_data_r.halted_now, out_duty_zero, "halt left wheels on")
  // stop mode never drives a wheel
  `EMC_ASSERT_NOW(a_stop_idle, mode_r == MODE_STOP, duty_zero, "stop mode with nonzero duty")
  // a disarmed distance request carries no goal
  `EMC_ASSERT_NOW(a_goal_disarm, dist_req_r == 24'd0, dist_goal_r == 32'd0, "stale distance goal")
  // each processed item shows up as a result in the next cycle
  `EMC_ASSERT_NEXT(a_adv_result, advance, out_valid_r, "processed item produced no result")

endmodule
